### src/nlfs_pkg.sv
// ----------------------------------------------------------------------------
// nlfs_pkg
// shared types and constants of the nearest live frontier selector
// ----------------------------------------------------------------------------
package nlfs_pkg;

  localparam int unsigned LiveDepthDef = 64;
  localparam int unsigned SetDepthDef  = 64;
  localparam int unsigned CoordW       = 24;
  localparam int unsigned IdW          = 32;

  localparam logic [2:0] FuncClear  = 3'd0;
  localparam logic [2:0] FuncAdd    = 3'd1;
  localparam logic [2:0] FuncArrive = 3'd2;
  localparam logic [2:0] FuncFail   = 3'd3;
  localparam logic [2:0] FuncSelect = 3'd4;

  localparam logic [1:0] DecAck      = 2'd0;
  localparam logic [1:0] DecNavigate = 2'd1;
  localparam logic [1:0] DecComplete = 2'd2;

  typedef struct packed {
    logic [2:0]              func;
    logic [IdW-1:0]          item_id;
    logic                    batch_first;
    logic signed [CoordW-1:0] frontier_x;
    logic signed [CoordW-1:0] frontier_y;
    logic                    mark_dead_flag;
    logic signed [CoordW-1:0] robot_x;
    logic signed [CoordW-1:0] robot_y;
  } req_t;

  typedef struct packed {
    logic                    accepted;
    logic [1:0]              decision;
    logic [IdW-1:0]          goal_id;
    logic signed [CoordW-1:0] goal_x;
    logic signed [CoordW-1:0] goal_y;
    logic                    overflow;
  } rsp_t;

endpackage

### src/nearest_live_frontier_selector.sv
// ----------------------------------------------------------------------------
// nearest_live_frontier_selector
// live frontier list with visited and dead id sets and nearest-goal search
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single
// response shows on rsp_o for one cycle with valid_o high and cannot be held
// off. Add scans both sets, one entry of each per cycle. Arrived scans the
// visited set and failed with mark_dead_flag scans the dead set; both then
// compact the live list one entry per cycle. Select streams the live list
// through the distance unit, one entry per cycle. The live list and the sets
// are simple dual-port memories, all with registered reads. No clearing pass
// after reset.
module nearest_live_frontier_selector #(
  parameter int unsigned LIVE_DEPTH = nlfs_pkg::LiveDepthDef,
  parameter int unsigned SET_DEPTH  = nlfs_pkg::SetDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  nlfs_pkg::req_t  req_i,
  output logic            busy,
  output logic            valid_o,
  output nlfs_pkg::rsp_t  rsp_o
);

  localparam int unsigned LA = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
  localparam int unsigned SA = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned LC = $clog2(LIVE_DEPTH + 1);
  localparam int unsigned SC = $clog2(SET_DEPTH + 1);
  localparam int unsigned IW = nlfs_pkg::IdW;
  localparam int unsigned CW = nlfs_pkg::CoordW;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StScan   = 9'b000000010,
    StAdd    = 9'b000000100,
    StSetWr  = 9'b000001000,
    StComp   = 9'b000010000,
    StSel    = 9'b000100000,
    StSelEnd = 9'b001000000,
    StResp   = 9'b010000000,
    StFetch  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [IW-1:0] mem_id  [LIVE_DEPTH];
  logic [CW-1:0] mem_x   [LIVE_DEPTH];
  logic [CW-1:0] mem_y   [LIVE_DEPTH];
  logic [IW-1:0] vis_mem [SET_DEPTH];
  logic [IW-1:0] dead_mem[SET_DEPTH];

  nlfs_pkg::req_t req_q;
  logic [LC-1:0] live_cnt_q, live_cnt_d;
  logic [SC-1:0] vis_cnt_q, vis_cnt_d, dead_cnt_q, dead_cnt_d;

  // set scan: address counter and registered read data
  logic [SC-1:0] sidx_q, sidx_d;
  logic          vrd_v_q, drd_v_q;
  logic [IW-1:0] vrd_q, drd_q;
  logic          hit_v_q, hit_v_d, hit_d_q, hit_d_d;

  // live walk
  logic [LC-1:0] ridx_q, ridx_d, widx_q, widx_d;
  logic          lrd_v_q, lrd_v2_q;
  logic [IW-1:0] lid_q;
  logic [CW-1:0] lx_q, ly_q;
  logic [IW-1:0] lid2_q, lid3_q;
  logic [CW-1:0] lx2_q, ly2_q, lx3_q, ly3_q;
  logic          lrd_v3_q;
  logic          live_we;
  logic [LA-1:0] live_wa;
  logic [IW-1:0] live_wid;
  logic [CW-1:0] live_wx, live_wy;

  logic [63:0]   dist_sq;
  logic [63:0]   best_d_q;
  logic          best_v_q;
  logic [IW-1:0] best_id_q;
  logic [CW-1:0] best_x_q, best_y_q;

  logic          ovf_q, ovf_d, acc_q, acc_d;
  logic [1:0]    dec_q, dec_d;
  logic          set_we_v, set_we_d;
  logic          scan_done, is_vis_op;

  assign busy = (state_q != StIdle);

  // memories
  always_ff @(posedge clk_i) begin
    if (live_we) begin
      mem_id[live_wa] <= live_wid;
      mem_x[live_wa]  <= live_wx;
      mem_y[live_wa]  <= live_wy;
    end
    lid_q <= mem_id[ridx_q[LA-1:0]];
    lx_q  <= mem_x[ridx_q[LA-1:0]];
    ly_q  <= mem_y[ridx_q[LA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (set_we_v) begin
      vis_mem[vis_cnt_q[SA-1:0]] <= req_q.item_id;
    end
    vrd_q <= vis_mem[sidx_q[SA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (set_we_d) begin
      dead_mem[dead_cnt_q[SA-1:0]] <= req_q.item_id;
    end
    drd_q <= dead_mem[sidx_q[SA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    lid2_q <= lid_q;
    lx2_q  <= lx_q;
    ly2_q  <= ly_q;
    lid3_q <= lid2_q;
    lx3_q  <= lx2_q;
    ly3_q  <= ly2_q;
  end

  nlfs_dist #(
    .CoordBits(CW)
  ) u_dist (
    .clk_i (clk_i),
    .fx_i  (lx_q),
    .fy_i  (ly_q),
    .rx_i  (req_q.robot_x),
    .ry_i  (req_q.robot_y),
    .dist_o(dist_sq)
  );

  assign is_vis_op = (req_q.func == nlfs_pkg::FuncArrive);

  // scan finished once no read is in flight and the counter passed every set the request scans
  always_comb begin
    scan_done = !vrd_v_q && !drd_v_q;
    if (req_q.func == nlfs_pkg::FuncAdd) begin
      scan_done = scan_done && (sidx_q >= vis_cnt_q) && (sidx_q >= dead_cnt_q);
    end else if (is_vis_op) begin
      scan_done = scan_done && (sidx_q >= vis_cnt_q);
    end else begin
      scan_done = scan_done && (sidx_q >= dead_cnt_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    live_cnt_d = live_cnt_q;
    vis_cnt_d  = vis_cnt_q;
    dead_cnt_d = dead_cnt_q;
    sidx_d     = sidx_q;
    ridx_d     = ridx_q;
    widx_d     = widx_q;
    hit_v_d    = hit_v_q;
    hit_d_d    = hit_d_q;
    ovf_d      = ovf_q;
    acc_d      = acc_q;
    dec_d      = dec_q;
    set_we_v   = 1'b0;
    set_we_d   = 1'b0;
    live_we    = 1'b0;
    live_wa    = widx_q[LA-1:0];
    live_wid   = lid_q;
    live_wx    = lx_q;
    live_wy    = ly_q;

    if (vrd_v_q && vrd_q == req_q.item_id) hit_v_d = 1'b1;
    if (drd_v_q && drd_q == req_q.item_id) hit_d_d = 1'b1;

    case (state_q)
      StIdle: begin
        if (start) begin
          sidx_d  = '0;
          ridx_d  = '0;
          widx_d  = '0;
          hit_v_d = 1'b0;
          hit_d_d = 1'b0;
          ovf_d   = 1'b0;
          acc_d   = 1'b0;
          dec_d   = nlfs_pkg::DecAck;
          case (req_i.func)
            nlfs_pkg::FuncClear: begin
              live_cnt_d = '0;
              vis_cnt_d  = '0;
              dead_cnt_d = '0;
              state_d    = StResp;
            end
            nlfs_pkg::FuncAdd: begin
              if (req_i.batch_first) live_cnt_d = '0;
              state_d = StScan;
            end
            nlfs_pkg::FuncArrive: state_d = StScan;
            nlfs_pkg::FuncFail: state_d = req_i.mark_dead_flag ? StScan : StResp;
            nlfs_pkg::FuncSelect: begin
              if (live_cnt_q == '0) begin
                dec_d   = nlfs_pkg::DecComplete;
                state_d = StResp;
              end else begin
                state_d = StSel;
              end
            end
            default: state_d = StResp;
          endcase
        end
      end
      StScan: begin
        if (sidx_q < vis_cnt_q || sidx_q < dead_cnt_q) sidx_d = sidx_q + 1'b1;
        if (scan_done) begin
          state_d = (req_q.func == nlfs_pkg::FuncAdd) ? StAdd : StSetWr;
        end
      end
      StAdd: begin
        if (!(hit_v_q || hit_d_q)) begin
          if (live_cnt_q >= LC'(LIVE_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            live_we    = 1'b1;
            live_wa    = live_cnt_q[LA-1:0];
            live_wid   = req_q.item_id;
            live_wx    = req_q.frontier_x;
            live_wy    = req_q.frontier_y;
            live_cnt_d = live_cnt_q + 1'b1;
            acc_d      = 1'b1;
          end
        end
        state_d = StResp;
      end
      StSetWr: begin
        if (is_vis_op) begin
          if (!hit_v_q) begin
            if (vis_cnt_q >= SC'(SET_DEPTH)) ovf_d = 1'b1;
            else begin
              set_we_v  = 1'b1;
              vis_cnt_d = vis_cnt_q + 1'b1;
            end
          end
        end else begin
          if (!hit_d_q) begin
            if (dead_cnt_q >= SC'(SET_DEPTH)) ovf_d = 1'b1;
            else begin
              set_we_d   = 1'b1;
              dead_cnt_d = dead_cnt_q + 1'b1;
            end
          end
        end
        state_d = StComp;
      end
      StComp: begin
        // read ahead, write back survivors in order
        if (ridx_q < live_cnt_q) ridx_d = ridx_q + 1'b1;
        if (lrd_v_q && lid_q != req_q.item_id) begin
          live_we = 1'b1;
          widx_d  = widx_q + 1'b1;
        end
        if (!lrd_v_q && ridx_q >= live_cnt_q) begin
          live_cnt_d = widx_q;
          state_d    = StResp;
        end
      end
      StSel: begin
        if (ridx_q < live_cnt_q) ridx_d = ridx_q + 1'b1;
        else state_d = StSelEnd;
      end
      StSelEnd: begin
        if (!lrd_v_q && !lrd_v2_q && !lrd_v3_q) begin
          dec_d   = nlfs_pkg::DecNavigate;
          state_d = StResp;
        end
      end
      StResp:  state_d = StIdle;
      StFetch: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      live_cnt_q <= '0;
      vis_cnt_q  <= '0;
      dead_cnt_q <= '0;
      sidx_q     <= '0;
      ridx_q     <= '0;
      widx_q     <= '0;
      hit_v_q    <= 1'b0;
      hit_d_q    <= 1'b0;
      vrd_v_q    <= 1'b0;
      drd_v_q    <= 1'b0;
      lrd_v_q    <= 1'b0;
      lrd_v2_q   <= 1'b0;
      lrd_v3_q   <= 1'b0;
      best_v_q   <= 1'b0;
      ovf_q      <= 1'b0;
      acc_q      <= 1'b0;
      dec_q      <= nlfs_pkg::DecAck;
      valid_o    <= 1'b0;
    end else begin
      state_q    <= state_d;
      live_cnt_q <= live_cnt_d;
      vis_cnt_q  <= vis_cnt_d;
      dead_cnt_q <= dead_cnt_d;
      sidx_q     <= sidx_d;
      ridx_q     <= ridx_d;
      widx_q     <= widx_d;
      hit_v_q    <= hit_v_d;
      hit_d_q    <= hit_d_d;
      ovf_q      <= ovf_d;
      acc_q      <= acc_d;
      dec_q      <= dec_d;
      vrd_v_q    <= (state_q == StScan) && (sidx_q < vis_cnt_q) &&
                    (req_q.func != nlfs_pkg::FuncFail);
      drd_v_q    <= (state_q == StScan) && (sidx_q < dead_cnt_q) && !is_vis_op;
      lrd_v_q    <= (state_q == StSel || state_q == StComp) && (ridx_q < live_cnt_q);
      lrd_v2_q   <= lrd_v_q && (state_q == StSel || state_q == StSelEnd);
      lrd_v3_q   <= lrd_v2_q;
      if (state_q == StIdle && start) best_v_q <= 1'b0;
      else if (lrd_v3_q) best_v_q <= 1'b1;
      valid_o    <= (state_q == StResp);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) req_q <= req_i;
    if (lrd_v3_q && (!best_v_q || dist_sq < best_d_q)) begin
      best_d_q  <= dist_sq;
      best_id_q <= lid3_q;
      best_x_q  <= lx3_q;
      best_y_q  <= ly3_q;
    end
  end

  always_comb begin
    rsp_o          = '0;
    rsp_o.accepted = acc_q;
    rsp_o.decision = dec_q;
    rsp_o.overflow = ovf_q;
    if (dec_q == nlfs_pkg::DecNavigate) begin
      rsp_o.goal_id = best_id_q;
      rsp_o.goal_x  = best_x_q;
      rsp_o.goal_y  = best_y_q;
    end
  end

endmodule

### src/nlfs_dist.sv
// ----------------------------------------------------------------------------
// nlfs_dist
// two-stage squared distance unit, one entry per cycle, full-width sum
// ----------------------------------------------------------------------------
module nlfs_dist #(
  parameter int unsigned CoordBits = nlfs_pkg::CoordW
) (
  input  logic                 clk_i,
  input  logic [CoordBits-1:0] fx_i,
  input  logic [CoordBits-1:0] fy_i,
  input  logic [CoordBits-1:0] rx_i,
  input  logic [CoordBits-1:0] ry_i,
  output logic [63:0]          dist_o
);

  localparam int unsigned DW = CoordBits + 1;

  logic signed [DW-1:0] ddx, ddy;
  logic [DW-1:0]        adx, ady;
  logic [DW-1:0]        adx_q, ady_q;
  logic [2*DW-1:0]      sx, sy;
  logic [2*DW:0]        sum;

  assign ddx = $signed({fx_i[CoordBits-1], fx_i}) - $signed({rx_i[CoordBits-1], rx_i});
  assign ddy = $signed({fy_i[CoordBits-1], fy_i}) - $signed({ry_i[CoordBits-1], ry_i});
  assign adx = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
  assign ady = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);

  always_ff @(posedge clk_i) begin
    adx_q <= adx;
    ady_q <= ady;
  end

  assign sx  = adx_q * adx_q;
  assign sy  = ady_q * ady_q;
  assign sum = {1'b0, sx} + {1'b0, sy};

  always_ff @(posedge clk_i) begin
    dist_o <= 64'(sum);
  end

endmodule

### src/nlfs_checker.sv
// ----------------------------------------------------------------------------
// nlfs_checker
// port-level checks of the selector, bound to the top level
// ----------------------------------------------------------------------------
module nlfs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           valid_o,
  input nlfs_pkg::rsp_t rsp_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request did not raise busy");

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("response longer than one cycle");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("busy while responding");

  a_dec_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rsp_o.decision == nlfs_pkg::DecAck ||
                 rsp_o.decision == nlfs_pkg::DecNavigate ||
                 rsp_o.decision == nlfs_pkg::DecComplete))
    else $error("illegal decision");

  a_acc_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.accepted |-> rsp_o.decision == nlfs_pkg::DecAck && !rsp_o.overflow)
    else $error("accepted with bad fields");

endmodule

bind nearest_live_frontier_selector nlfs_checker u_nlfs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .valid_o(valid_o),
  .rsp_o  (rsp_o)
);

### bench/tb_nearest_live_frontier_selector.sv
// ----------------------------------------------------------------------------
// tb_nearest_live_frontier_selector
// directed and randomized request streams against a behavioral model of
// the frontier list, the visited and dead sets and the nearest-goal
// search; every response is compared field by field in request order
// ----------------------------------------------------------------------------
module tb_nearest_live_frontier_selector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LiveN = 64;
  localparam int SetN  = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  nlfs_pkg::req_t req_i = '0;
  logic busy;
  logic valid_o;
  nlfs_pkg::rsp_t rsp_o;

  nearest_live_frontier_selector DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .valid_o(valid_o), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // frontier model state
  logic [31:0] m_ids [LiveN];
  logic signed [23:0] m_xs [LiveN];
  logic signed [23:0] m_ys [LiveN];
  int m_live;
  logic [31:0] m_vis [SetN];
  int m_nvis;
  logic [31:0] m_dead [SetN];
  int m_ndead;

  nlfs_pkg::req_t pending_reqs[$];
  nlfs_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  bit quiet = 1'b0;
  int gap = 0;
  logic [31:0] id_pool [16];

  function automatic void queue_req(input nlfs_pkg::req_t q);
    pending_reqs = {pending_reqs, q};
  endfunction

  function automatic bit in_set(input logic [31:0] s [SetN], input int n,
                                input logic [31:0] id);
    for (int i = 0; i < n; i++) if (s[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_live(input logic [31:0] id);
    int w;
    w = 0;
    for (int r = 0; r < m_live; r++) begin
      if (m_ids[r] != id) begin
        m_ids[w] = m_ids[r]; m_xs[w] = m_xs[r]; m_ys[w] = m_ys[r]; w++;
      end
    end
    m_live = w;
  endfunction

  function automatic logic [63:0] sq_dist(input logic signed [23:0] fx, fy, rx, ry);
    logic [63:0] dx, dy, sx, sy, s;
    longint a, b;
    a = fx - rx; b = fy - ry;
    dx = (a < 0) ? -a : a;
    dy = (b < 0) ? -b : b;
    sx = dx * dx; sy = dy * dy; s = sx + sy;
    if (s < sx) s = '1;
    return s;
  endfunction

  function automatic nlfs_pkg::rsp_t predict_rsp(input nlfs_pkg::req_t q);
    nlfs_pkg::rsp_t r;
    int best;
    logic [63:0] bd, d;
    r = '0;
    case (q.func)
      nlfs_pkg::FuncClear: begin
        m_live = 0; m_nvis = 0; m_ndead = 0;
      end
      nlfs_pkg::FuncAdd: begin
        if (q.batch_first) m_live = 0;
        if (!in_set(m_vis, m_nvis, q.item_id) && !in_set(m_dead, m_ndead, q.item_id)) begin
          if (m_live >= LiveN) r.overflow = 1'b1;
          else begin
            m_ids[m_live] = q.item_id; m_xs[m_live] = q.frontier_x;
            m_ys[m_live] = q.frontier_y; m_live++; r.accepted = 1'b1;
          end
        end
      end
      nlfs_pkg::FuncArrive: begin
        if (!in_set(m_vis, m_nvis, q.item_id)) begin
          if (m_nvis >= SetN) r.overflow = 1'b1;
          else begin m_vis[m_nvis] = q.item_id; m_nvis++; end
        end
        drop_live(q.item_id);
      end
      nlfs_pkg::FuncFail: begin
        if (q.mark_dead_flag) begin
          if (!in_set(m_dead, m_ndead, q.item_id)) begin
            if (m_ndead >= SetN) r.overflow = 1'b1;
            else begin m_dead[m_ndead] = q.item_id; m_ndead++; end
          end
          drop_live(q.item_id);
        end
      end
      nlfs_pkg::FuncSelect: begin
        if (m_live == 0) r.decision = nlfs_pkg::DecComplete;
        else begin
          best = 0;
          bd = sq_dist(m_xs[0], m_ys[0], q.robot_x, q.robot_y);
          for (int i = 1; i < m_live; i++) begin
            d = sq_dist(m_xs[i], m_ys[i], q.robot_x, q.robot_y);
            if (d < bd) begin bd = d; best = i; end
          end
          r.decision = nlfs_pkg::DecNavigate;
          r.goal_id = m_ids[best]; r.goal_x = m_xs[best]; r.goal_y = m_ys[best];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic nlfs_pkg::req_t rand_req(input bit noisy);
    nlfs_pkg::req_t q;
    q = '0;
    q.item_id = id_pool[$urandom_range(0, 15)];
    q.frontier_x = rand_coord(); q.frontier_y = rand_coord();
    q.robot_x = rand_coord(); q.robot_y = rand_coord();
    q.batch_first = ($urandom_range(0, 9) == 0);
    q.mark_dead_flag = 1'($urandom);
    if (noisy) begin
      q.func = 3'($urandom);
      q.item_id = $urandom;
      q.batch_first = 1'($urandom);
    end else begin
      case ($urandom_range(0, 19))
        0: q.func = nlfs_pkg::FuncClear;
        1, 2, 3, 4, 5, 6, 7, 8: q.func = nlfs_pkg::FuncAdd;
        9, 10, 11: q.func = nlfs_pkg::FuncArrive;
        12, 13: q.func = nlfs_pkg::FuncFail;
        default: q.func = nlfs_pkg::FuncSelect;
      endcase
    end
    return q;
  endfunction

  bit taken;
  always @(posedge clk_i) taken <= start && !busy;

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !taken) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0 && !(start && !taken)) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          gap <= $urandom_range(1, 10) - 1;
          start <= 1'b0;
        end else begin
          req_i <= pending_reqs.pop_front();
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // record expectation when the request is accepted
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) expected_rsps = {expected_rsps, predict_rsp(req_i)};
  end

  // monitor
  always @(posedge clk_i) begin
    nlfs_pkg::rsp_t e;
    if (rst_ni && valid_o) begin
      if (expected_rsps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %h", rsp_o);
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_o.accepted !== e.accepted || rsp_o.decision !== e.decision ||
            rsp_o.goal_id !== e.goal_id || rsp_o.goal_x !== e.goal_x ||
            rsp_o.goal_y !== e.goal_y || rsp_o.overflow !== e.overflow) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %h got %h", e, rsp_o);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    nlfs_pkg::req_t q;
    m_live = 0; m_nvis = 0; m_ndead = 0;
    for (int i = 0; i < 16; i++) id_pool[i] = (i < 2) ? (i ? 32'hffffffff : 32'h0) : $urandom;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // directed: complete on empty, extremes, duplicates, removals, unused codes
    q = '0; q.func = nlfs_pkg::FuncSelect; queue_req(q);
    q = '0; q.func = nlfs_pkg::FuncAdd; q.batch_first = 1'b1; q.item_id = '1;
    q.frontier_x = 24'sh7fffff; q.frontier_y = 24'sh7fffff; queue_req(q);
    q.batch_first = 1'b0; q.item_id = '0;
    q.frontier_x = 24'sh800000; q.frontier_y = 24'sh800000; queue_req(q);
    q.item_id = '1; q.frontier_x = 24'sh800000; q.frontier_y = 24'sh7fffff;
    queue_req(q);
    q = '0; q.func = nlfs_pkg::FuncSelect; q.robot_x = 24'sh7fffff; q.robot_y = 24'sh7fffff;
    queue_req(q);
    q.robot_x = 24'sh800000; q.robot_y = 24'sh800000; queue_req(q);
    q = '0; q.func = nlfs_pkg::FuncFail; q.item_id = '1; queue_req(q);
    q.mark_dead_flag = 1'b1; queue_req(q);
    queue_req(q);
    q = '0; q.func = nlfs_pkg::FuncAdd; q.item_id = '1; q.batch_first = 1'b1; queue_req(q);
    q = '0; q.func = nlfs_pkg::FuncArrive; queue_req(q);
    q = '0; q.func = nlfs_pkg::FuncSelect; queue_req(q);
    for (int f = 5; f < 8; f++) begin q = '1; q.func = 3'(f); queue_req(q); end
    // fill the live list and the visited set past capacity, and grow the dead set
    for (int i = 0; i < 66; i++) begin
      q = '0; q.func = nlfs_pkg::FuncAdd; q.item_id = 32'h100 + i; q.frontier_x = 24'(i);
      queue_req(q);
    end
    q = '0; q.func = nlfs_pkg::FuncSelect; q.robot_x = 24'sh7fffff; queue_req(q);
    for (int i = 0; i < 66; i++) begin
      q = '0; q.func = (i % 2) ? nlfs_pkg::FuncArrive : nlfs_pkg::FuncFail;
      q.mark_dead_flag = 1'b1;
      q.item_id = 32'h200 + i; queue_req(q);
      q.item_id = 32'h300 + i; q.func = nlfs_pkg::FuncArrive; queue_req(q);
    end
    q = '0; q.func = nlfs_pkg::FuncClear; queue_req(q);
    for (int i = 0; i < 1200; i++) queue_req(rand_req($urandom_range(0, 9) == 0));
    for (int i = 0; i < 200; i++) queue_req(rand_req(1'b0));
    while (pending_reqs.size() > 200) @(posedge clk_i);
    quiet = 1'b1;
    while (pending_reqs.size() > 0 || start) @(posedge clk_i);
    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
